@@ hw/rtl/bic_pkg.sv @@
// ----------------------------------------------------------------------------
// bic_pkg
// Shared types, register indexes, reset values and helpers for the battery
// indicator controller.
// ----------------------------------------------------------------------------
package bic_pkg;

   // Widths fixed by the overlay interface.
   localparam int unsigned LevelWidth = 7;
   localparam int unsigned ColorWidth = 32;
   localparam int unsigned TicksWidth = 16;
   localparam int unsigned AttrWidth  = 3;
   localparam int unsigned AttrCount  = 5;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   localparam int unsigned CountWidthDefault = 16;

   // Depth of the queue between the front and back parts.
   localparam int unsigned QueueDepth      = 4;
   localparam int unsigned QueuePtrWidth   = $clog2(QueueDepth);
   localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [LevelWidth-1:0] LevelFull = 7'd100;

   // Overlay attribute codes.
   localparam logic [AttrWidth-1:0] AttrColor    = 3'd0;
   localparam logic [AttrWidth-1:0] AttrPercent  = 3'd1;
   localparam logic [AttrWidth-1:0] AttrShowPct  = 3'd2;
   localparam logic [AttrWidth-1:0] AttrCharging = 3'd3;
   localparam logic [AttrWidth-1:0] AttrEnable   = 3'd4;

   // Register indexes.
   localparam logic [CsrIndexWidth-1:0] CsrGaugeReliable = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrLowLevel      = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrBlinkHalf     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrShowTicks     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrNormalColor   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrAlertColor    = 3'd5;

   // Register reset values.
   localparam logic                  GaugeReliableReset = 1'b1;
   localparam logic [LevelWidth-1:0] LowLevelReset      = 7'd10;
   localparam logic [TicksWidth-1:0] BlinkHalfReset     = 16'd500;
   localparam logic [TicksWidth-1:0] ShowTicksReset     = 16'd3000;
   localparam logic [ColorWidth-1:0] NormalColorReset   = 32'hffff_ffff;
   localparam logic [ColorWidth-1:0] AlertColorReset    = 32'hffff_0000;

   typedef struct packed {
      logic                  sample_valid;
      logic [LevelWidth-1:0] level_reading;
      logic                  is_charging;
      logic                  app_active;
      logic                  key_pressed;
   } bic_req_type;

   typedef struct packed {
      logic [AttrWidth-1:0]  attribute;
      logic [ColorWidth-1:0] value;
      logic                  last;
   } bic_rsp_type;

   typedef struct packed {
      logic                  gauge_reliable;
      logic [LevelWidth-1:0] low_level;
      logic [TicksWidth-1:0] blink_half_ticks;
      logic [TicksWidth-1:0] show_ticks;
      logic [ColorWidth-1:0] normal_color;
      logic [ColorWidth-1:0] alert_color;
   } bic_cfg_type;

   // One set of overlay writes: a bit per attribute that changed, plus values.
   typedef struct packed {
      logic [AttrCount-1:0]  mask;
      logic [ColorWidth-1:0] color;
      logic [LevelWidth-1:0] percent;
      logic                  show_flag;
      logic                  charging;
      logic                  enable;
   } bic_entry_type;

   // Rounds a percentage (at most 100) to the nearest quarter, halves rounding up.
   function automatic logic [LevelWidth-1:0] bic_quarter(input logic [LevelWidth-1:0] cap);
      logic [LevelWidth-1:0] result;
      if (cap >= 7'd88) begin
         result = 7'd100;
      end else if (cap >= 7'd63) begin
         result = 7'd75;
      end else if (cap >= 7'd38) begin
         result = 7'd50;
      end else if (cap >= 7'd13) begin
         result = 7'd25;
      end else begin
         result = 7'd0;
      end
      return result;
   endfunction

endpackage

@@ hw/rtl/battery_indicator_controller.sv @@
// ----------------------------------------------------------------------------
// battery_indicator_controller
// Battery-level overlay controller: one request per time tick, a response per
// overlay attribute that changed.
// ----------------------------------------------------------------------------
// A request is taken in any cycle in which the internal queue has room: the
// front part updates the level, mode and countdowns in the accepting cycle and
// queues the attributes that changed, so requests may arrive back to back.
// Each request produces zero to five responses in the order colour, percent,
// show percent, charging, enable, the final one marked by last. The response
// serializer sends one response per cycle while the output is not stalled by
// rsp_ready; an accepted request passes through the queue, the current-set
// register and the response register, and up to four requests wait in the
// queue. Registers may be written only while no responses are pending.
// ----------------------------------------------------------------------------
module battery_indicator_controller #(
   parameter int unsigned COUNT_WIDTH = bic_pkg::CountWidthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bic_pkg::bic_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bic_pkg::bic_rsp_type                 rsp_data,
   input  logic                                 csr_write_en,
   input  logic [bic_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [bic_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import bic_pkg::*;

   bic_cfg_type   cfg_ff, cfg_in;
   bic_entry_type push_entry, head_entry;
   logic          push, pop, q_empty, q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CsrGaugeReliable: cfg_in.gauge_reliable   = csr_wdata[0];
            CsrLowLevel:      cfg_in.low_level        = csr_wdata[LevelWidth-1:0];
            CsrBlinkHalf:     cfg_in.blink_half_ticks = csr_wdata[TicksWidth-1:0];
            CsrShowTicks:     cfg_in.show_ticks       = csr_wdata[TicksWidth-1:0];
            CsrNormalColor:   cfg_in.normal_color     = csr_wdata[ColorWidth-1:0];
            CsrAlertColor:    cfg_in.alert_color      = csr_wdata[ColorWidth-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gauge_reliable   <= GaugeReliableReset;
         cfg_ff.low_level        <= LowLevelReset;
         cfg_ff.blink_half_ticks <= BlinkHalfReset;
         cfg_ff.show_ticks       <= ShowTicksReset;
         cfg_ff.normal_color     <= NormalColorReset;
         cfg_ff.alert_color      <= AlertColorReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bic_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .queue_full  (q_full),
      .queue_push  (push),
      .queue_entry (push_entry)
   );

   bic_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (q_empty),
      .full       (q_full)
   );

   bic_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_entry  (head_entry),
      .queue_empty (q_empty),
      .queue_pop   (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

@@ hw/rtl/bic_front.sv @@
// ----------------------------------------------------------------------------
// bic_front
// Takes one tick per request, updates the indicator state and countdowns, and
// queues the set of overlay attributes that changed.
// ----------------------------------------------------------------------------
module bic_front #(
   parameter int unsigned COUNT_WIDTH = bic_pkg::CountWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bic_pkg::bic_req_type  req_data,
   input  bic_pkg::bic_cfg_type  cfg,
   input  logic                  queue_full,
   output logic                  queue_push,
   output bic_pkg::bic_entry_type queue_entry
);
   import bic_pkg::*;

   localparam logic [32:0] CountMaxWide = (33'd1 << COUNT_WIDTH) - 33'd1;
   localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

   // Loads into the countdowns saturate at the counter width.
   function automatic logic [COUNT_WIDTH-1:0] count_load(input logic [TicksWidth-1:0] v);
      logic [32:0] wide;
      wide = 33'(v);
      if (wide > CountMaxWide) begin
         return CountMaxWide[COUNT_WIDTH-1:0];
      end
      return wide[COUNT_WIDTH-1:0];
   endfunction

   logic [LevelWidth-1:0]  shown_level_ff, shown_level_in;
   logic                   charging_now_ff, charging_now_in;
   logic                   app_owns_ff, app_owns_in;
   logic                   blink_phase_ff, blink_phase_in;
   logic [COUNT_WIDTH-1:0] blink_count_ff, blink_count_in;
   logic [COUNT_WIDTH-1:0] show_count_ff, show_count_in;
   logic                   pushed_valid_ff;
   logic [ColorWidth-1:0]  pushed_color_ff;
   logic [LevelWidth-1:0]  pushed_percent_ff;
   logic                   pushed_show_ff, pushed_charging_ff, pushed_enable_ff;

   logic [LevelWidth-1:0]  cap;
   logic [COUNT_WIDTH-1:0] blink_work;
   logic                   accept;
   bic_entry_type          entry;

   assign req_ready   = !queue_full;
   assign accept      = req_valid && req_ready;
   assign queue_push  = accept && (entry.mask != '0);
   assign queue_entry = entry;

   always_comb begin
      cap = (req_data.level_reading > LevelFull) ? LevelFull : req_data.level_reading;
      if (!cfg.gauge_reliable) begin
         cap = bic_quarter(cap);
      end

      charging_now_in = charging_now_ff;
      app_owns_in     = app_owns_ff;
      shown_level_in  = shown_level_ff;
      if (req_data.sample_valid) begin
         charging_now_in = req_data.is_charging;
         app_owns_in     = req_data.app_active;
         if (req_data.is_charging || (cap < shown_level_ff)) begin
            shown_level_in = cap;
         end
      end

      entry.color     = cfg.normal_color;
      entry.percent   = shown_level_in;
      entry.show_flag = 1'b1;
      entry.charging  = 1'b0;
      entry.enable    = 1'b0;
      blink_phase_in  = blink_phase_ff;
      blink_work      = blink_count_ff;

      if (charging_now_in) begin
         entry.charging  = 1'b1;
         entry.show_flag = cfg.gauge_reliable;
         entry.enable    = 1'b1;
      end else if (shown_level_in < cfg.low_level) begin
         entry.color = cfg.alert_color;
         if (blink_count_ff == '0) begin
            blink_phase_in = !blink_phase_ff;
            blink_work     = count_load(cfg.blink_half_ticks);
         end
         entry.enable = blink_phase_in;
      end else if (show_count_ff != '0) begin
         entry.enable = 1'b1;
      end

      if (app_owns_in) begin
         entry.enable = 1'b0;
      end

      entry.mask[AttrColor]    = !pushed_valid_ff || (entry.color != pushed_color_ff);
      entry.mask[AttrPercent]  = !pushed_valid_ff || (entry.percent != pushed_percent_ff);
      entry.mask[AttrShowPct]  = !pushed_valid_ff || (entry.show_flag != pushed_show_ff);
      entry.mask[AttrCharging] = !pushed_valid_ff || (entry.charging != pushed_charging_ff);
      entry.mask[AttrEnable]   = !pushed_valid_ff || (entry.enable != pushed_enable_ff);

      blink_count_in = (blink_work != '0) ? (blink_work - CountOne) : blink_work;
      show_count_in  = (show_count_ff != '0) ? (show_count_ff - CountOne) : show_count_ff;
      // A key press shows the overlay from the next tick on.
      if (req_data.key_pressed && !charging_now_in && (shown_level_in >= cfg.low_level)) begin
         show_count_in = count_load(cfg.show_ticks);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_level_ff  <= LevelFull;
         charging_now_ff <= 1'b0;
         app_owns_ff     <= 1'b0;
         blink_phase_ff  <= 1'b0;
         blink_count_ff  <= '0;
         show_count_ff   <= '0;
         pushed_valid_ff <= 1'b0;
      end else if (accept) begin
         shown_level_ff  <= shown_level_in;
         charging_now_ff <= charging_now_in;
         app_owns_ff     <= app_owns_in;
         blink_phase_ff  <= blink_phase_in;
         blink_count_ff  <= blink_count_in;
         show_count_ff   <= show_count_in;
         pushed_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pushed_color_ff    <= entry.color;
         pushed_percent_ff  <= entry.percent;
         pushed_show_ff     <= entry.show_flag;
         pushed_charging_ff <= entry.charging;
         pushed_enable_ff   <= entry.enable;
      end
   end

endmodule

@@ hw/rtl/bic_queue.sv @@
// ----------------------------------------------------------------------------
// bic_queue
// Small first-in first-out queue of pending attribute write sets between the
// front and back parts.
// ----------------------------------------------------------------------------
module bic_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bic_pkg::bic_entry_type push_entry,
   input  logic                   pop,
   output bic_pkg::bic_entry_type head_entry,
   output logic                   empty,
   output logic                   full
);
   import bic_pkg::*;

   localparam logic [QueueCountWidth-1:0] CountFull = QueueCountWidth'(QueueDepth);
   localparam logic [QueuePtrWidth-1:0]   PtrLast   = QueuePtrWidth'(QueueDepth - 1);

   bic_entry_type              slot_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CountFull);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : (rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/bic_back.sv @@
// ----------------------------------------------------------------------------
// bic_back
// Walks the changed attributes of each queued write set in attribute order
// and presents them one per cycle when not stalled, via a response register.
// ----------------------------------------------------------------------------
module bic_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bic_pkg::bic_entry_type head_entry,
   input  logic                   queue_empty,
   output logic                   queue_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bic_pkg::bic_rsp_type   rsp_data
);
   import bic_pkg::*;

   bic_entry_type        cur_ff, cur_in;
   logic [AttrCount-1:0] rem_ff, rem_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bic_rsp_type          rsp_ff, rsp_in;

   logic                 slot_free, emit;
   logic [AttrCount-1:0] rem_after;
   logic [AttrWidth-1:0] pick;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = slot_free && (rem_ff != '0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      pick = AttrEnable;
      for (int i = AttrCount - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            pick = AttrWidth'(i);
         end
      end
      rem_after       = rem_ff;
      rem_after[pick] = 1'b0;

      rsp_in.attribute = pick;
      rsp_in.last      = (rem_after == '0);
      case (pick)
         AttrColor:    rsp_in.value = cur_ff.color;
         AttrPercent:  rsp_in.value = ColorWidth'(cur_ff.percent);
         AttrShowPct:  rsp_in.value = ColorWidth'(cur_ff.show_flag);
         AttrCharging: rsp_in.value = ColorWidth'(cur_ff.charging);
         AttrEnable:   rsp_in.value = ColorWidth'(cur_ff.enable);
         default:      rsp_in.value = '0;
      endcase

      rsp_valid_in = slot_free ? emit : rsp_valid_ff;

      // The next set is taken as soon as the current one is used up, so the
      // output keeps moving without a gap cycle.
      queue_pop = !queue_empty && ((rem_ff == '0) || (emit && (rem_after == '0)));
      rem_in    = emit ? rem_after : rem_ff;
      cur_in    = cur_ff;
      if (queue_pop) begin
         cur_in = head_entry;
         rem_in = head_entry.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
